[src/bffa_pkg.sv]
// Shared types and constants of the bitmap first-fit allocator.
package bffa_pkg;

  // Build-time defaults.
  localparam int HEAP_CAPACITY_DEF = 1024;
  localparam int MARKER_SLOTS_DEF  = 64;

  // Reset value of the managed-size register.
  localparam logic [10:0] HEAP_BYTES_RESET = 11'd1024;

  // Command codes.
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSPACE  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTALLOC = 2'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_SCAN,
    S_A_MARK,
    S_A_HINT,
    S_F_BIT0,
    S_F_BIT1,
    S_F_MSCAN,
    S_F_CLEAR,
    S_F_SHIFT,
    S_RESP
  } state_t;

endpackage

[src/bitmap_first_fit_allocator.sv]
// Bitmap first-fit heap allocator with a sequenced bitmap and end-marker memory.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, command,              | request
//          | request_size, block_offset                |
//  out     | out_valid, out_ready, status,             | response
//          | result_offset, result_size                |
//  cfg     | cfg_valid, cfg_ready, cfg_data            | register write
//
// One word is processed at a time; the bitmap memory is walked one byte per cycle
// and the marker memory one entry per cycle. Allocate scans the bitmap from the hint,
// marks the block bytes and, if the block starts at the hint, skips the busy bytes
// behind it to move the hint. Free checks the start bits, scans the live markers,
// clears the block bytes and shifts the later markers; query only checks and scans;
// a rejected word goes straight to the response. After reset a clearing pass over all
// HEAP_CAPACITY bytes empties the bitmap while in_ready stays low. A finished response
// waits in the output register until taken, and the next request is accepted meanwhile.
module bitmap_first_fit_allocator #(
  parameter int HEAP_CAPACITY = bffa_pkg::HEAP_CAPACITY_DEF,
  parameter int MARKER_SLOTS  = bffa_pkg::MARKER_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [10:0] request_size,
  input  logic [9:0]  block_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [9:0]  result_offset,
  output logic [10:0] result_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  localparam int AW   = $clog2(HEAP_CAPACITY);
  localparam int PW   = $clog2(HEAP_CAPACITY + 1);
  localparam int CW   = (PW > 11) ? PW : 11;
  localparam int MW   = $clog2(MARKER_SLOTS);
  localparam int CNTW = $clog2(MARKER_SLOTS + 1);

  bffa_pkg::state_t state, state_next;

  logic [10:0]     heap_bytes;
  logic [PW-1:0]   n_bytes;
  logic [PW-1:0]   idx, idx_next;
  logic [PW-1:0]   run, run_next;
  logic [PW-1:0]   start, start_next;
  logic [PW-1:0]   hint, hint_next;
  logic [PW-1:0]   end_pos, end_next;
  logic [CNTW-1:0] mcount, mcount_next;
  logic [CNTW-1:0] midx, midx_next;
  logic [CNTW-1:0] best, best_next;
  logic [CNTW:0]   midx_inc;
  logic [CNTW:0]   mk_raddr;
  logic [PW-1:0]   bestv, bestv_next;
  logic            found, found_next;
  logic            is_eq, is_eq_next;
  logic            prev_busy, prev_busy_next;
  logic [1:0]      cmd_r;
  logic [CW-1:0]   req_r;
  logic [9:0]      off_r;
  logic [1:0]      res_status, res_status_next;
  logic [9:0]      res_off, res_off_next;
  logic [10:0]     res_size, res_size_next;

  // Memories and their write controls.
  logic            bm_mem [HEAP_CAPACITY];
  logic            bm_q;
  logic            bm_we, bm_wd;
  logic [PW-1:0]   mk_mem [MARKER_SLOTS];
  logic [PW-1:0]   mk_q;
  logic            mk_we;
  logic [MW-1:0]   mk_waddr;
  logic [PW-1:0]   mk_wd;

  // Shared conditions.
  logic accept, alloc_bad, table_full, off_out, scan_go, span_last;
  logic hint_go, mscan_go, ok_start, shift_go, resp_load;
  logic [PW-1:0] blk_end;

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state == bffa_pkg::S_IDLE);
  assign cfg_ready  = 1'b1;
  assign n_bytes    = (CW'(heap_bytes) > CW'(HEAP_CAPACITY)) ? PW'(HEAP_CAPACITY)
                                                               : PW'(heap_bytes);
  assign alloc_bad  = (request_size == 11'd0) || (CW'(request_size) > CW'(n_bytes));
  assign table_full = (mcount >= CNTW'(MARKER_SLOTS));
  assign off_out    = CW'(block_offset) >= CW'(HEAP_CAPACITY);
  assign scan_go    = (idx < n_bytes) && (run < PW'(req_r));
  assign span_last  = (idx == end_pos - PW'(1));
  assign hint_go    = (idx < n_bytes) && bm_q;
  assign mscan_go   = (midx < mcount);
  assign ok_start   = !prev_busy || is_eq;
  assign midx_inc   = {1'b0, midx} + (CNTW + 1)'(1);
  assign shift_go   = (midx_inc < {1'b0, mcount});
  assign blk_end    = found ? bestv : PW'(HEAP_CAPACITY);
  assign resp_load  = (state == bffa_pkg::S_RESP) && (!out_valid || out_ready);

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      bffa_pkg::S_CLEAR: begin
        if (idx == PW'(HEAP_CAPACITY - 1)) state_next = bffa_pkg::S_IDLE;
      end
      bffa_pkg::S_IDLE: begin
        if (accept) begin
          if (command == bffa_pkg::CMD_ALLOC) begin
            state_next = (alloc_bad || table_full) ? bffa_pkg::S_RESP : bffa_pkg::S_A_SCAN;
          end else if (command == bffa_pkg::CMD_FREE || command == bffa_pkg::CMD_QUERY) begin
            state_next = off_out ? bffa_pkg::S_RESP : bffa_pkg::S_F_BIT0;
          end else begin
            state_next = bffa_pkg::S_RESP;
          end
        end
      end
      bffa_pkg::S_A_SCAN: begin
        if (!scan_go) begin
          state_next = (run == PW'(req_r)) ? bffa_pkg::S_A_MARK : bffa_pkg::S_RESP;
        end
      end
      bffa_pkg::S_A_MARK: begin
        if (span_last) begin
          state_next = (start == hint) ? bffa_pkg::S_A_HINT : bffa_pkg::S_RESP;
        end
      end
      bffa_pkg::S_A_HINT: begin
        if (!hint_go) state_next = bffa_pkg::S_RESP;
      end
      bffa_pkg::S_F_BIT0: begin
        if (!bm_q) state_next = bffa_pkg::S_RESP;
        else if (off_r == 10'd0) state_next = bffa_pkg::S_F_MSCAN;
        else state_next = bffa_pkg::S_F_BIT1;
      end
      bffa_pkg::S_F_BIT1: begin
        state_next = bffa_pkg::S_F_MSCAN;
      end
      bffa_pkg::S_F_MSCAN: begin
        if (!mscan_go) begin
          if (!ok_start || cmd_r == bffa_pkg::CMD_QUERY) state_next = bffa_pkg::S_RESP;
          else state_next = bffa_pkg::S_F_CLEAR;
        end
      end
      bffa_pkg::S_F_CLEAR: begin
        if (span_last) state_next = found ? bffa_pkg::S_F_SHIFT : bffa_pkg::S_RESP;
      end
      bffa_pkg::S_F_SHIFT: begin
        if (!shift_go) state_next = bffa_pkg::S_RESP;
      end
      bffa_pkg::S_RESP: begin
        if (resp_load) state_next = bffa_pkg::S_IDLE;
      end
      default: state_next = bffa_pkg::S_IDLE;
    endcase
  end

  // Datapath next values and memory controls.
  always_comb begin
    idx_next        = idx;
    run_next        = run;
    start_next      = start;
    hint_next       = hint;
    end_next        = end_pos;
    mcount_next     = mcount;
    midx_next       = midx;
    best_next       = best;
    bestv_next      = bestv;
    found_next      = found;
    is_eq_next      = is_eq;
    prev_busy_next  = prev_busy;
    res_status_next = res_status;
    res_off_next    = res_off;
    res_size_next   = res_size;
    bm_we           = 1'b0;
    bm_wd           = 1'b0;
    mk_we           = 1'b0;
    mk_waddr        = midx[MW-1:0];
    mk_wd           = mk_q;
    case (state)
      bffa_pkg::S_CLEAR: begin
        bm_we    = 1'b1;
        idx_next = idx + PW'(1);
      end
      bffa_pkg::S_IDLE: begin
        if (accept) begin
          res_status_next = bffa_pkg::ST_NOSPACE;
          res_off_next    = 10'd0;
          res_size_next   = 11'd0;
          prev_busy_next  = 1'b0;
          if (command == bffa_pkg::CMD_ALLOC) begin
            if (!alloc_bad && table_full) res_status_next = bffa_pkg::ST_FULL;
            idx_next   = hint;
            run_next   = '0;
            start_next = hint;
          end else if (command == bffa_pkg::CMD_FREE || command == bffa_pkg::CMD_QUERY) begin
            if (off_out) res_status_next = bffa_pkg::ST_NOTALLOC;
            idx_next = PW'(block_offset);
          end
        end
      end
      bffa_pkg::S_A_SCAN: begin
        if (scan_go) begin
          if (bm_q) begin
            run_next   = '0;
            start_next = idx + PW'(1);
          end else begin
            run_next = run + PW'(1);
          end
          idx_next = idx + PW'(1);
        end else if (run == PW'(req_r)) begin
          idx_next = start;
          end_next = PW'(CW'(start) + req_r);
        end
      end
      bffa_pkg::S_A_MARK: begin
        bm_we    = 1'b1;
        bm_wd    = 1'b1;
        idx_next = idx + PW'(1);
        if (span_last) begin
          mk_we           = 1'b1;
          mk_waddr        = mcount[MW-1:0];
          mk_wd           = end_pos;
          mcount_next     = mcount + CNTW'(1);
          res_status_next = bffa_pkg::ST_OK;
          res_off_next    = 10'(start);
          res_size_next   = 11'(req_r);
        end
      end
      bffa_pkg::S_A_HINT: begin
        if (hint_go) idx_next = idx + PW'(1);
        else hint_next = idx;
      end
      bffa_pkg::S_F_BIT0: begin
        if (!bm_q) begin
          res_status_next = bffa_pkg::ST_NOTALLOC;
        end else begin
          idx_next   = idx - PW'(1);
          midx_next  = '0;
          found_next = 1'b0;
          is_eq_next = 1'b0;
        end
      end
      bffa_pkg::S_F_BIT1: begin
        prev_busy_next = bm_q;
      end
      bffa_pkg::S_F_MSCAN: begin
        if (mscan_go) begin
          if (CW'(mk_q) == CW'(off_r)) is_eq_next = 1'b1;
          if (CW'(mk_q) > CW'(off_r) && (!found || mk_q < bestv)) begin
            found_next = 1'b1;
            best_next  = midx;
            bestv_next = mk_q;
          end
          midx_next = midx + CNTW'(1);
        end else if (!ok_start) begin
          res_status_next = bffa_pkg::ST_NOTALLOC;
        end else begin
          res_status_next = bffa_pkg::ST_OK;
          res_off_next    = off_r;
          res_size_next   = 11'(CW'(blk_end) - CW'(off_r));
          end_next        = blk_end;
          idx_next        = PW'(off_r);
          if (cmd_r == bffa_pkg::CMD_FREE && PW'(off_r) < hint) hint_next = PW'(off_r);
        end
      end
      bffa_pkg::S_F_CLEAR: begin
        bm_we    = 1'b1;
        idx_next = idx + PW'(1);
        if (span_last) midx_next = best;
      end
      bffa_pkg::S_F_SHIFT: begin
        if (shift_go) begin
          mk_we     = 1'b1;
          midx_next = midx + CNTW'(1);
        end else begin
          mcount_next = mcount - CNTW'(1);
        end
      end
      default: begin
      end
    endcase
    // Marker read runs one entry ahead while shifting.
    mk_raddr = (state_next == bffa_pkg::S_F_SHIFT) ? ({1'b0, midx_next} + (CNTW + 1)'(1))
                                                   : {1'b0, midx_next};
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bffa_pkg::S_CLEAR;
      idx        <= '0;
      hint       <= '0;
      mcount     <= '0;
      heap_bytes <= bffa_pkg::HEAP_BYTES_RESET;
      out_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      hint   <= hint_next;
      mcount <= mcount_next;
      if (cfg_valid && cfg_ready) heap_bytes <= cfg_data;
      if (resp_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk) begin
    run        <= run_next;
    start      <= start_next;
    end_pos    <= end_next;
    midx       <= midx_next;
    best       <= best_next;
    bestv      <= bestv_next;
    found      <= found_next;
    is_eq      <= is_eq_next;
    prev_busy  <= prev_busy_next;
    res_status <= res_status_next;
    res_off    <= res_off_next;
    res_size   <= res_size_next;
    if (accept) begin
      cmd_r <= command;
      req_r <= CW'(request_size);
      off_r <= block_offset;
    end
    if (resp_load) begin
      status        <= res_status;
      result_offset <= res_off;
      result_size   <= res_size;
    end
  end

  // Busy bitmap: read follows the next byte index.
  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[idx[AW-1:0]] <= bm_wd;
    bm_q <= bm_mem[idx_next[AW-1:0]];
  end

  // End-marker table.
  always_ff @(posedge clk) begin
    if (mk_we) mk_mem[mk_waddr] <= mk_wd;
    mk_q <= mk_mem[mk_raddr[MW-1:0]];
  end

endmodule

[dv/tb.sv]
// Self-checking testbench for the bitmap first-fit heap allocator.
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT = 20000;
  // Command code that the block does not define.
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  command = bffa_pkg::CMD_ALLOC;
  logic [10:0] request_size = '0;
  logic [9:0]  block_offset = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  status;
  logic [9:0]  result_offset;
  logic [10:0] result_size;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_off = 0;
  int unsigned words_sent = 0;
  int unsigned settings_used = 0;
  logic [9:0]  live_starts [$];

  task automatic report_error(string msg);
    error_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Scoreboard: keeps its own copy of the heap state and the queue of expected words.
  class heap_scoreboard;
    bit          busy [1024];
    int unsigned ends [64];
    int unsigned live_blocks;
    int unsigned free_hint;
    int unsigned managed_size;
    logic [1:0]  exp_status [$];
    logic [9:0]  exp_offset [$];
    logic [10:0] exp_size [$];
    int unsigned n_ok;

    function void reset_state();
      foreach (busy[i]) busy[i] = 0;
      live_blocks = 0;
      free_hint = 0;
      managed_size = 1024;
    endfunction

    function void set_size(logic [10:0] v);
      managed_size = v;
    endfunction

    function bit has_marker(int unsigned v);
      for (int i = 0; i < live_blocks; i++)
        if (ends[i] == v) return 1;
      return 0;
    endfunction

    // Records one accepted request and predicts its response word.
    function void note_request(logic [1:0] cmd, logic [10:0] req, logic [9:0] off);
      int unsigned n, run, start, i, e, idx;
      logic [1:0] st;
      int unsigned roff, rsize;
      bit is_start;
      n = (managed_size > 1024) ? 1024 : managed_size;
      st = bffa_pkg::ST_NOSPACE;
      roff = 0;
      rsize = 0;
      if (cmd == bffa_pkg::CMD_ALLOC) begin
        if (req == 0 || req > n) begin
          st = bffa_pkg::ST_NOSPACE;
        end else if (live_blocks >= 64) begin
          st = bffa_pkg::ST_FULL;
        end else begin
          run = 0;
          start = free_hint;
          for (i = free_hint; i < n && run < req; i++) begin
            if (busy[i]) begin
              run = 0;
              start = i + 1;
            end else begin
              run++;
            end
          end
          if (run == req) begin
            e = start + req;
            for (i = start; i < e; i++) busy[i] = 1;
            ends[live_blocks] = e;
            live_blocks++;
            if (start == free_hint) begin
              i = e;
              while (i < n && busy[i]) i++;
              free_hint = i;
            end
            st = bffa_pkg::ST_OK;
            roff = start;
            rsize = req;
          end
        end
      end else if (cmd == bffa_pkg::CMD_FREE || cmd == bffa_pkg::CMD_QUERY) begin
        is_start = busy[off] && (off == 0 || !busy[off - 1] || has_marker(off));
        if (!is_start) begin
          st = bffa_pkg::ST_NOTALLOC;
        end else begin
          idx = 64;
          e = 1024;
          for (i = 0; i < live_blocks; i++)
            if (ends[i] > off && (idx == 64 || ends[i] < e)) begin
              idx = i;
              e = ends[i];
            end
          if (idx == 64) e = 1024;
          if (cmd == bffa_pkg::CMD_FREE) begin
            for (i = off; i < e; i++) busy[i] = 0;
            if (off < free_hint) free_hint = off;
            if (idx < live_blocks) begin
              for (i = idx; i + 1 < live_blocks; i++) ends[i] = ends[i + 1];
              live_blocks--;
            end
          end
          st = bffa_pkg::ST_OK;
          roff = off;
          rsize = e - off;
        end
      end
      exp_status.push_back(st);
      exp_offset.push_back(roff[9:0]);
      exp_size.push_back(rsize[10:0]);
    endfunction

    // Compares one response word with the oldest prediction.
    task check_response(logic [1:0] st, logic [9:0] off, logic [10:0] sz);
      logic [1:0] es;
      logic [9:0] eo;
      logic [10:0] ez;
      if (exp_status.size() == 0) begin
        report_error($sformatf("unexpected response st=%0d off=%0d size=%0d", st, off, sz));
        return;
      end
      es = exp_status.pop_front();
      eo = exp_offset.pop_front();
      ez = exp_size.pop_front();
      if (st !== es)
        report_error($sformatf("status %0d, expected %0d", st, es));
      else if (off !== eo)
        report_error($sformatf("offset %0d, expected %0d", off, eo));
      else if (sz !== ez)
        report_error($sformatf("size %0d, expected %0d", sz, ez));
      if (st === es && st == bffa_pkg::ST_OK) n_ok++;
    endtask

    function int pending();
      return exp_status.size();
    endfunction
  endclass

  heap_scoreboard heap_sb;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  bitmap_first_fit_allocator i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .request_size(request_size), .block_offset(block_offset),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .result_offset(result_offset), .result_size(result_size),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Sends one request word after a random gap and notes it when accepted.
  // Valid stays high after acceptance when the next word follows with no gap.
  task automatic send_request(logic [1:0] cmd, logic [10:0] req, logic [9:0] off);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    command <= cmd;
    request_size <= req;
    block_offset <= off;
    do @(posedge clk); while (!in_ready);
    heap_sb.note_request(cmd, req, off);
    if (cmd == bffa_pkg::CMD_ALLOC && heap_sb.exp_status[$] == bffa_pkg::ST_OK)
      live_starts.push_back(heap_sb.exp_offset[$]);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (heap_sb.pending() != 0) @(posedge clk);
    repeat (2200) @(posedge clk);
  endtask

  // Writes the managed-size register; the block must be idle.
  task automatic write_size(logic [10:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    heap_sb.set_size(v);
    settings_used++;
  endtask

  // Picks an offset for free or query, mostly a live block start.
  function automatic logic [9:0] pick_offset();
    if (live_starts.size() != 0 && $urandom_range(0, 9) < 8)
      return live_starts[$urandom_range(0, live_starts.size() - 1)];
    return 10'($urandom);
  endfunction

  task automatic random_phase(int count);
    int k, r;
    logic [10:0] sz;
    logic [9:0] off;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        sz = ($urandom_range(0, 19) == 0) ? 11'($urandom) : 11'($urandom_range(1, 40));
        send_request(bffa_pkg::CMD_ALLOC, sz, 10'($urandom));
      end else if (r < 80) begin
        off = pick_offset();
        send_request(bffa_pkg::CMD_FREE, 11'($urandom), off);
        foreach (live_starts[i])
          if (live_starts[i] == off && heap_sb.exp_status[$] == bffa_pkg::ST_OK) begin
            live_starts.delete(i);
            break;
          end
      end else if (r < 97) begin
        send_request(bffa_pkg::CMD_QUERY, 11'($urandom), pick_offset());
      end else begin
        send_request(CMD_UNKNOWN, 11'($urandom), 10'($urandom));
      end
    end
  endtask

  // Response side: random stalls plus one long hold-off.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off != 0) begin
        out_ready <= 0;
        hold_off--;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (stall != 0 && out_ready) begin
          out_ready <= 0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1;
      end
    end
  end

  // Checks every response word taken at a clock edge.
  always @(posedge clk)
    if (!rst && out_valid && out_ready)
      heap_sb.check_response(status, result_offset, result_size);

  // Watchdog on cycles with no accepted word.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired with %0d words outstanding", heap_sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Main stimulus sequence.
  initial begin
    int j;
    heap_sb = new();
    heap_sb.reset_state();
    repeat (7) @(posedge clk);
    rst <= 0;

    // Directed: error cases, extremes, fill and drain of the marker table.
    send_request(bffa_pkg::CMD_ALLOC, 11'd0, 10'd0);
    send_request(bffa_pkg::CMD_ALLOC, 11'd1025, 10'd0);
    send_request(bffa_pkg::CMD_ALLOC, 11'h7FF, 10'h3FF);
    send_request(bffa_pkg::CMD_FREE, 11'd0, 10'd0);
    send_request(bffa_pkg::CMD_QUERY, 11'd0, 10'h3FF);
    send_request(CMD_UNKNOWN, 11'h7FF, 10'h3FF);
    send_request(bffa_pkg::CMD_ALLOC, 11'd1024, 10'd0);
    send_request(bffa_pkg::CMD_QUERY, 11'd0, 10'd0);
    send_request(bffa_pkg::CMD_FREE, 11'd0, 10'd0);
    send_request(bffa_pkg::CMD_ALLOC, 11'd3, 10'd0);
    send_request(bffa_pkg::CMD_ALLOC, 11'd5, 10'd0);
    send_request(bffa_pkg::CMD_QUERY, 11'd0, 10'd3);
    send_request(bffa_pkg::CMD_FREE, 11'd0, 10'd4);
    send_request(bffa_pkg::CMD_FREE, 11'd0, 10'd0);
    send_request(bffa_pkg::CMD_ALLOC, 11'd2, 10'd0);
    send_request(bffa_pkg::CMD_ALLOC, 11'd1019, 10'd0);
    send_request(bffa_pkg::CMD_ALLOC, 11'd1, 10'd0);
    wait_drained();
    // Release the directed blocks; one of the offsets is not a block start.
    live_starts.delete();
    send_request(bffa_pkg::CMD_FREE, 11'd0, 10'd0);
    send_request(bffa_pkg::CMD_FREE, 11'd0, 10'd3);
    send_request(bffa_pkg::CMD_FREE, 11'd0, 10'd5);

    // Fill the marker table to hit the full status, with the output held off.
    hold_off = 300;
    for (j = 0; j < 66; j++) send_request(bffa_pkg::CMD_ALLOC, 11'd1, 10'd0);
    for (j = 0; j < 64; j += 2) send_request(bffa_pkg::CMD_FREE, 11'd0, 10'(j));
    for (j = 1; j < 64; j += 2) send_request(bffa_pkg::CMD_FREE, 11'd0, 10'(j));
    // Sender pause until every response is back.
    wait_drained();

    // Random phases under several register settings, extremes included.
    write_size(11'd1);
    random_phase(40);
    wait_drained();
    write_size(11'd0);
    random_phase(30);
    wait_drained();
    write_size(11'h7FF);
    random_phase(200);
    wait_drained();
    write_size(11'($urandom_range(8, 200)));
    random_phase(200);
    wait_drained();
    write_size(11'd1024);
    random_phase(350);
    wait_drained();

    $display("Sent %0d request words over %0d size settings; %0d ok responses checked.",
             words_sent, settings_used, heap_sb.n_ok);
    if (error_count == 0 && heap_sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

[sim.f]
src/bffa_pkg.sv
src/bitmap_first_fit_allocator.sv
dv/tb.sv
